// File: hdl/lsp_pkg.sv
// ----------------------------------------------------------------------------
// lsp_pkg
// shared types and constants of the line sensor pid drive
// ----------------------------------------------------------------------------
package lsp_pkg;

    localparam int N_SENS    = 8;
    localparam int SENS_IW   = 3;
    localparam int FRAC_BITS = 16;

    localparam int CMD_W = 2;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd0;
    localparam logic [CMD_W-1:0] CMD_CAL   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_TICK  = 2'd2;

    localparam int CFG_IW = 3;
    localparam int CFG_DW = 40;
    localparam logic [CFG_IW-1:0] CFG_PROP   = 3'd0;
    localparam logic [CFG_IW-1:0] CFG_INTEG  = 3'd1;
    localparam logic [CFG_IW-1:0] CFG_DERIV  = 3'd2;
    localparam logic [CFG_IW-1:0] CFG_TARGET = 3'd3;
    localparam logic [CFG_IW-1:0] CFG_CRUISE = 3'd4;
    localparam logic [CFG_IW-1:0] CFG_SEARCH = 3'd5;
    localparam logic [CFG_IW-1:0] CFG_THRESH = 3'd6;

    localparam int GAIN_W   = 32;
    localparam int IGAIN_W  = 40;
    localparam int TARGET_W = 23;
    localparam int SPEED_W  = 7;
    localparam int THR_W    = 16;

    localparam int MUL_AW = 47;
    localparam int MUL_BW = 40;
    localparam int MUL_PW = MUL_AW + MUL_BW;

    localparam int WGT_W   = 22;
    localparam int ACC_W   = 64;
    localparam int POS_W   = 25;
    localparam int ERR_W   = 26;
    localparam int DERR_W  = 27;
    localparam int INTEG_W = 48;
    localparam int TERM_W  = 42;
    localparam int PSUM_W  = 44;
    localparam int PID_W   = 25;
    localparam int MOTOR_W = 25;
    localparam int DUTY_W  = 7;

    localparam longint POS_LIM   = 64'd13107200;
    localparam longint PID_LIM   = 64'd10485760;
    localparam longint MOTOR_LIM = 64'd11796480;
    localparam longint INTEG_LIM = 64'd140737488355327;
    localparam logic [DUTY_W-1:0] DUTY_MAX = 7'd100;

    localparam int P_SHIFT = 24;
    localparam int I_SHIFT = 40;
    localparam int TERM_LIM_BITS = 40;

    typedef struct packed {
        logic              rr;
        logic [DUTY_W-1:0] rd;
        logic              lr;
        logic [DUTY_W-1:0] ld;
    } t_drive;

    // weight magnitude, sensors 0..3 carry a negative sign
    function automatic logic [WGT_W-1:0] weight_mag(input logic [SENS_IW-1:0] idx);
        logic [1:0] j;
        j = idx[2] ? idx[1:0] : ~idx[1:0];
        case (j)
            2'd0:    weight_mag = 22'd469238;
            2'd1:    weight_mag = 22'd1405092;
            2'd2:    weight_mag = 22'd2340946;
            default: weight_mag = 22'd3276800;
        endcase
    endfunction

endpackage

// File: hdl/lsp_div.sv
// ----------------------------------------------------------------------------
// lsp_div
// bit-serial restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module lsp_div #(
    parameter int SAMPLE_BITS = 12
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [SAMPLE_BITS-1:0]    i_num_mag,
    input  logic [SAMPLE_BITS-1:0]    i_den_mag,
    output logic                      o_done,
    output logic [SAMPLE_BITS+15:0]   o_quot
);
    import lsp_pkg::*;

    localparam int S  = SAMPLE_BITS;
    localparam int DW = S + FRAC_BITS;
    localparam int CW = $clog2(DW + 1);

    logic          r_busy, r_done;
    logic [CW-1:0] r_cnt;
    logic [S-1:0]  r_rem, r_den;
    logic [DW-1:0] r_quo;
    logic [S:0]    w_try, w_diff;
    logic          w_ge;

    always_comb begin
        w_try  = {r_rem, r_quo[DW-1]};
        w_ge   = w_try >= {1'b0, r_den};
        w_diff = w_try - {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(DW);
                r_rem  <= '0;
                r_den  <= i_den_mag;
                r_quo  <= {i_num_mag, {FRAC_BITS{1'b0}}};
            end else if (r_busy) begin
                r_rem <= w_ge ? w_diff[S-1:0] : w_try[S-1:0];
                r_quo <= {r_quo[DW-2:0], w_ge};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo;

endmodule

// File: hdl/lsp_mul.sv
// ----------------------------------------------------------------------------
// lsp_mul
// bit-serial shift-add multiplier, one multiplier bit per cycle
// ----------------------------------------------------------------------------
module lsp_mul (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [lsp_pkg::MUL_AW-1:0] i_a,
    input  logic [lsp_pkg::MUL_BW-1:0] i_b,
    output logic                       o_done,
    output logic [lsp_pkg::MUL_PW-1:0] o_prod
);
    import lsp_pkg::*;

    localparam int CW = $clog2(MUL_BW + 1);

    logic              r_busy, r_done;
    logic [CW-1:0]     r_cnt;
    logic [MUL_AW-1:0] r_a;
    logic [MUL_PW:0]   r_p;
    logic [MUL_AW:0]   w_sum;

    assign w_sum = r_p[MUL_PW:MUL_BW] + (r_p[0] ? {1'b0, r_a} : '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(MUL_BW);
                r_a    <= i_a;
                r_p    <= {{(MUL_AW+1){1'b0}}, i_b};
            end else if (r_busy) begin
                r_p   <= {1'b0, w_sum, r_p[MUL_BW-1:1]};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_prod = r_p[MUL_PW-1:0];

endmodule

// File: hdl/line_sensor_pid_drive.sv
// ----------------------------------------------------------------------------
// line_sensor_pid_drive
// line sensor calibration, position estimate, pid and motor mix
// ----------------------------------------------------------------------------
// input channel i_valid/o_ready carries a command and eight samples; the
// output channel o_valid/i_ready returns one drive item per input item.
// registers are written through i_cfg_valid/o_cfg_ready with i_cfg_index
// and i_cfg_data, always ready; the user must write them only while the
// block is idle, the block does not enforce this. one item is worked on
// at a time. a control tick runs per sensor one serial divide of
// SAMPLE_BITS+16 quotient bits, skipped when the calibrated range is zero,
// and one serial multiply over 40 multiplier bits, then three more
// multiplies for the pid terms, all on one shared divider and multiplier.
// the next item is accepted while a finished result waits in the output
// register; a stalled receiver holds the block at its last step.
// synchronous reset restores register defaults, clears calibration,
// pid state and the held drive.
// ----------------------------------------------------------------------------
module line_sensor_pid_drive #(
    parameter int SAMPLE_BITS = 12
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [lsp_pkg::CMD_W-1:0]    i_cmd,
    input  logic [SAMPLE_BITS-1:0]       i_sample0,
    input  logic [SAMPLE_BITS-1:0]       i_sample1,
    input  logic [SAMPLE_BITS-1:0]       i_sample2,
    input  logic [SAMPLE_BITS-1:0]       i_sample3,
    input  logic [SAMPLE_BITS-1:0]       i_sample4,
    input  logic [SAMPLE_BITS-1:0]       i_sample5,
    input  logic [SAMPLE_BITS-1:0]       i_sample6,
    input  logic [SAMPLE_BITS-1:0]       i_sample7,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [lsp_pkg::DUTY_W-1:0]   o_left_duty,
    output logic                         o_left_reverse,
    output logic [lsp_pkg::DUTY_W-1:0]   o_right_duty,
    output logic                         o_right_reverse,
    output logic                         o_on_line,
    output logic signed [lsp_pkg::POS_W-1:0] o_line_position,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [lsp_pkg::CFG_IW-1:0]   i_cfg_index,
    input  logic [lsp_pkg::CFG_DW-1:0]   i_cfg_data
);
    import lsp_pkg::*;

    localparam int S  = SAMPLE_BITS;
    localparam int DW = S + FRAC_BITS;
    localparam int NW = S + 18;

    localparam logic [1:0] TERM_P = 2'd0;
    localparam logic [1:0] TERM_I = 2'd1;
    localparam logic [1:0] TERM_D = 2'd2;

    typedef enum logic [9:0] {
        S_IDLE   = 10'b0000000001,
        S_NSTART = 10'b0000000010,
        S_NDIV   = 10'b0000000100,
        S_WSTART = 10'b0000001000,
        S_WMUL   = 10'b0000010000,
        S_POS    = 10'b0000100000,
        S_MSTART = 10'b0001000000,
        S_MWAIT  = 10'b0010000000,
        S_MIX    = 10'b0100000000,
        S_DONE   = 10'b1000000000
    } t_state;

    t_state r_state;

    logic [GAIN_W-1:0]         r_prop, r_deriv;
    logic [IGAIN_W-1:0]        r_igain;
    logic signed [TARGET_W-1:0] r_target;
    logic [SPEED_W-1:0]        r_cruise, r_search;
    logic [THR_W-1:0]          r_thr;

    logic [S-1:0] r_cal_min [N_SENS];
    logic [S-1:0] r_cal_max [N_SENS];
    logic [S-1:0] r_samp    [N_SENS];
    logic [S-1:0] w_in_samp [N_SENS];
    logic [CMD_W-1:0] r_cmd;

    logic [SENS_IW-1:0]        r_idx;
    logic [1:0]                r_k;
    logic signed [NW-1:0]      r_norm;
    logic [N_SENS-1:0]         r_seen;
    logic signed [ACC_W-1:0]   r_acc;
    logic signed [POS_W-1:0]   r_pos;
    logic signed [ERR_W-1:0]   r_err, r_last_err;
    logic signed [DERR_W-1:0]  r_derr;
    logic signed [INTEG_W-1:0] r_integ;
    logic signed [PSUM_W-1:0]  r_pid_sum;
    logic                      r_mneg;
    logic                      r_on_line, r_lseen, r_rseen;
    t_drive                    r_held;

    logic                      r_out_valid;
    t_drive                    r_out_drive;
    logic                      r_out_on_line;
    logic signed [POS_W-1:0]   r_out_pos;

    // sensor datapath
    logic [S-1:0]         w_smp, w_min, w_max;
    logic signed [S:0]    w_num, w_den, w_num_neg, w_den_neg;
    logic [S-1:0]         w_num_mag, w_den_mag;
    logic                 w_div_neg, w_div_start, w_div_done;
    logic [DW-1:0]        w_quot;
    logic signed [NW-1:0] w_q, w_norm_div, w_norm_next, w_thr2, w_one, w_norm_mag;
    logic                 w_in_acc;

    assign w_in_samp[0] = i_sample0;
    assign w_in_samp[1] = i_sample1;
    assign w_in_samp[2] = i_sample2;
    assign w_in_samp[3] = i_sample3;
    assign w_in_samp[4] = i_sample4;
    assign w_in_samp[5] = i_sample5;
    assign w_in_samp[6] = i_sample6;
    assign w_in_samp[7] = i_sample7;

    always_comb begin
        w_smp      = r_samp[r_idx];
        w_min      = r_cal_min[r_idx];
        w_max      = r_cal_max[r_idx];
        w_num      = $signed({1'b0, w_smp}) - $signed({1'b0, w_min});
        w_den      = $signed({1'b0, w_max}) - $signed({1'b0, w_min});
        w_num_neg  = -w_num;
        w_den_neg  = -w_den;
        w_num_mag  = w_num[S] ? w_num_neg[S-1:0] : w_num[S-1:0];
        w_den_mag  = w_den[S] ? w_den_neg[S-1:0] : w_den[S-1:0];
        w_div_neg  = w_num[S] ^ w_den[S];
        w_one      = $signed(NW'(1) << FRAC_BITS);
        w_q        = $signed({2'b00, w_quot});
        w_norm_div = w_div_neg ? (w_one + w_q) : (w_one - w_q);
        w_norm_next = (w_den == '0) ? w_one : w_norm_div;
        w_thr2     = $signed({{(NW-THR_W-1){1'b0}}, r_thr, 1'b0});
        w_norm_mag = r_norm[NW-1] ? -r_norm : r_norm;
    end

    assign w_div_start = (r_state == S_NSTART) && (w_den != '0);

    lsp_div #(
        .SAMPLE_BITS(SAMPLE_BITS)
    ) u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_div_start),
        .i_num_mag (w_num_mag),
        .i_den_mag (w_den_mag),
        .o_done    (w_div_done),
        .o_quot    (w_quot)
    );

    // multiplier operands
    logic signed [INTEG_W-1:0] w_sel;
    logic [INTEG_W-1:0]        w_sel_mag;
    logic [MUL_AW-1:0]         w_ma;
    logic [MUL_BW-1:0]         w_mb;
    logic                      w_sel_neg, w_mul_start, w_mul_done;
    logic [MUL_PW-1:0]         w_prod;

    always_comb begin
        case (r_k)
            TERM_P:  w_sel = INTEG_W'(r_err);
            TERM_I:  w_sel = r_integ;
            default: w_sel = INTEG_W'(r_derr);
        endcase
        w_sel_neg = w_sel[INTEG_W-1];
        w_sel_mag = w_sel_neg ? -w_sel : w_sel;
        if (r_state == S_WSTART) begin
            w_ma = MUL_AW'(weight_mag(r_idx));
            w_mb = {{(MUL_BW-NW){1'b0}}, w_norm_mag};
        end else begin
            w_ma = w_sel_mag[MUL_AW-1:0];
            case (r_k)
                TERM_P:  w_mb = MUL_BW'(r_prop);
                TERM_I:  w_mb = r_igain;
                default: w_mb = MUL_BW'(r_deriv);
            endcase
        end
    end

    assign w_mul_start = (r_state == S_WSTART) || (r_state == S_MSTART);

    lsp_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mul_start),
        .i_a     (w_ma),
        .i_b     (w_mb),
        .o_done  (w_mul_done),
        .o_prod  (w_prod)
    );

    // weighted sum term
    logic                    w_wneg;
    logic signed [ACC_W-1:0] w_wprod;

    always_comb begin
        w_wneg  = ~r_idx[2] ^ r_norm[NW-1];
        w_wprod = w_wneg ? -$signed(w_prod[ACC_W-1:0]) : $signed(w_prod[ACC_W-1:0]);
    end

    // pid term scaling: floor of shifted product, saturated to 2^40
    logic [MUL_PW-1:0]        w_qsh;
    logic                     w_rem, w_sat;
    logic [TERM_LIM_BITS:0]   w_qt;
    logic signed [TERM_W-1:0] w_term;

    always_comb begin
        if (r_k == TERM_I) begin
            w_qsh = w_prod >> I_SHIFT;
            w_rem = |w_prod[I_SHIFT-1:0];
        end else begin
            w_qsh = w_prod >> P_SHIFT;
            w_rem = |w_prod[P_SHIFT-1:0];
        end
        w_sat = |w_qsh[MUL_PW-1:TERM_LIM_BITS];
        if (w_sat)
            w_qt = {1'b1, {TERM_LIM_BITS{1'b0}}};
        else
            w_qt = {1'b0, w_qsh[TERM_LIM_BITS-1:0]} + (TERM_LIM_BITS+1)'(r_mneg & w_rem);
        w_term = r_mneg ? -$signed({1'b0, w_qt}) : $signed({1'b0, w_qt});
    end

    // position, error and integral
    logic signed [ACC_W-1:0]   w_pos_full;
    logic signed [POS_W-1:0]   w_pos;
    logic signed [ERR_W-1:0]   w_err;
    logic signed [DERR_W-1:0]  w_derr;
    logic signed [INTEG_W:0]   w_isum;
    logic signed [INTEG_W-1:0] w_integ;

    always_comb begin
        w_pos_full = r_acc >>> FRAC_BITS;
        if (w_pos_full > POS_LIM)
            w_pos = POS_W'(POS_LIM);
        else if (w_pos_full < -POS_LIM)
            w_pos = POS_W'(-POS_LIM);
        else
            w_pos = w_pos_full[POS_W-1:0];
        w_err  = ERR_W'(w_pos) - ERR_W'(r_target);
        w_derr = DERR_W'(w_err) - DERR_W'(r_last_err);
        w_isum = (INTEG_W+1)'(r_integ) + (INTEG_W+1)'(w_err);
        if (w_isum > INTEG_LIM)
            w_integ = INTEG_W'(INTEG_LIM);
        else if (w_isum < -INTEG_LIM)
            w_integ = INTEG_W'(-INTEG_LIM);
        else
            w_integ = w_isum[INTEG_W-1:0];
    end

    // motor mix
    logic signed [PID_W-1:0]   w_pid;
    logic signed [MOTOR_W:0]   w_cru, w_lsum, w_rsum;
    logic signed [MOTOR_W-1:0] w_lm, w_rm, w_lmag, w_rmag;
    logic [SPEED_W-1:0]        w_sp;
    logic                      w_on_line;
    t_drive                    w_drive;

    always_comb begin
        if (r_pid_sum > PID_LIM)
            w_pid = PID_W'(PID_LIM);
        else if (r_pid_sum < -PID_LIM)
            w_pid = PID_W'(-PID_LIM);
        else
            w_pid = r_pid_sum[PID_W-1:0];
        w_cru  = $signed({2'b00, r_cruise, 17'b0});
        w_lsum = w_cru + (MOTOR_W+1)'(w_pid);
        w_rsum = w_cru - (MOTOR_W+1)'(w_pid);
        if (w_lsum > MOTOR_LIM)
            w_lm = MOTOR_W'(MOTOR_LIM);
        else if (w_lsum < -MOTOR_LIM)
            w_lm = MOTOR_W'(-MOTOR_LIM);
        else
            w_lm = w_lsum[MOTOR_W-1:0];
        if (w_rsum > MOTOR_LIM)
            w_rm = MOTOR_W'(MOTOR_LIM);
        else if (w_rsum < -MOTOR_LIM)
            w_rm = MOTOR_W'(-MOTOR_LIM);
        else
            w_rm = w_rsum[MOTOR_W-1:0];
        w_lmag    = w_lm[MOTOR_W-1] ? -w_lm : w_lm;
        w_rmag    = w_rm[MOTOR_W-1] ? -w_rm : w_rm;
        w_sp      = (r_search > DUTY_MAX) ? DUTY_MAX : r_search;
        w_on_line = |r_seen[5:2];
        w_drive   = r_held;
        if (w_on_line) begin
            w_drive.ld = w_lmag[23:17];
            w_drive.lr = w_lm[MOTOR_W-1];
            w_drive.rd = w_rmag[23:17];
            w_drive.rr = w_rm[MOTOR_W-1];
        end else if (r_rseen) begin
            w_drive = '{rr: 1'b0, rd: w_sp, lr: 1'b1, ld: w_sp};
        end else if (r_lseen) begin
            w_drive = '{rr: 1'b1, rd: w_sp, lr: 1'b0, ld: w_sp};
        end
    end

    assign o_ready     = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign w_in_acc    = i_valid && o_ready;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prop   <= 32'd1677722;
            r_igain  <= 40'd109951;
            r_deriv  <= 32'd41943040;
            r_target <= '0;
            r_cruise <= 7'd80;
            r_search <= 7'd70;
            r_thr    <= 16'd16384;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_PROP:   r_prop   <= i_cfg_data[GAIN_W-1:0];
                CFG_INTEG:  r_igain  <= i_cfg_data[IGAIN_W-1:0];
                CFG_DERIV:  r_deriv  <= i_cfg_data[GAIN_W-1:0];
                CFG_TARGET: r_target <= $signed(i_cfg_data[TARGET_W-1:0]);
                CFG_CRUISE: r_cruise <= i_cfg_data[SPEED_W-1:0];
                CFG_SEARCH: r_search <= i_cfg_data[SPEED_W-1:0];
                CFG_THRESH: r_thr    <= i_cfg_data[THR_W-1:0];
                default: ;
            endcase
        end
    end

    // calibration store
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < N_SENS; i++) begin
                r_cal_min[i] <= '1;
                r_cal_max[i] <= '0;
            end
        end else if (w_in_acc) begin
            for (int i = 0; i < N_SENS; i++) begin
                if (i_cmd == CMD_CLEAR) begin
                    r_cal_min[i] <= '1;
                    r_cal_max[i] <= '0;
                end else if (i_cmd == CMD_CAL) begin
                    if (w_in_samp[i] > r_cal_max[i])
                        r_cal_max[i] <= w_in_samp[i];
                    if (w_in_samp[i] < r_cal_min[i])
                        r_cal_min[i] <= w_in_samp[i];
                end
            end
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_integ    <= '0;
            r_last_err <= '0;
            r_lseen    <= 1'b0;
            r_rseen    <= 1'b0;
            r_held     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_ready && r_state != S_DONE)
                r_out_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        r_cmd <= i_cmd;
                        for (int i = 0; i < N_SENS; i++)
                            r_samp[i] <= w_in_samp[i];
                        r_idx <= '0;
                        r_acc <= '0;
                        r_state <= (i_cmd == CMD_TICK) ? S_NSTART : S_DONE;
                    end
                end
                S_NSTART: begin
                    if (w_den == '0) begin
                        r_norm        <= w_norm_next;
                        r_seen[r_idx] <= w_norm_next > w_thr2;
                        r_state       <= S_WSTART;
                    end else begin
                        r_state <= S_NDIV;
                    end
                end
                S_NDIV: begin
                    if (w_div_done) begin
                        r_norm        <= w_norm_next;
                        r_seen[r_idx] <= w_norm_next > w_thr2;
                        r_state       <= S_WSTART;
                    end
                end
                S_WSTART: r_state <= S_WMUL;
                S_WMUL: begin
                    if (w_mul_done) begin
                        r_acc <= r_acc + w_wprod;
                        if (r_idx == SENS_IW'(N_SENS - 1)) begin
                            r_state <= S_POS;
                        end else begin
                            r_idx   <= r_idx + 1'b1;
                            r_state <= S_NSTART;
                        end
                    end
                end
                S_POS: begin
                    r_pos      <= w_pos;
                    r_err      <= w_err;
                    r_derr     <= w_derr;
                    r_integ    <= w_integ;
                    r_last_err <= w_err;
                    r_pid_sum  <= '0;
                    r_k        <= TERM_P;
                    r_state    <= S_MSTART;
                end
                S_MSTART: begin
                    r_mneg  <= w_sel_neg;
                    r_state <= S_MWAIT;
                end
                S_MWAIT: begin
                    if (w_mul_done) begin
                        r_pid_sum <= r_pid_sum + PSUM_W'(w_term);
                        if (r_k == TERM_D) begin
                            r_state <= S_MIX;
                        end else begin
                            r_k     <= r_k + 1'b1;
                            r_state <= S_MSTART;
                        end
                    end
                end
                S_MIX: begin
                    r_held    <= w_drive;
                    r_on_line <= w_on_line;
                    r_rseen   <= |r_seen[2:0];
                    r_lseen   <= |r_seen[7:5];
                    r_state   <= S_DONE;
                end
                S_DONE: begin
                    if (!r_out_valid || i_ready) begin
                        r_out_valid   <= 1'b1;
                        r_out_drive   <= r_held;
                        r_out_on_line <= (r_cmd == CMD_TICK) ? r_on_line : 1'b0;
                        r_out_pos     <= (r_cmd == CMD_TICK) ? r_pos : '0;
                        r_state       <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid         = r_out_valid;
    assign o_left_duty     = r_out_drive.ld;
    assign o_left_reverse  = r_out_drive.lr;
    assign o_right_duty    = r_out_drive.rd;
    assign o_right_reverse = r_out_drive.rr;
    assign o_on_line       = r_out_on_line;
    assign o_line_position = r_out_pos;

    a_units_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_div_start && w_mul_start))
        else $error("divider and multiplier started together");

    a_tick_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && i_cmd == CMD_TICK) |=> (r_state == S_NSTART && r_idx == '0))
        else $error("tick item did not start at sensor zero");

    a_held_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_held.ld <= DUTY_MAX) && (r_held.rd <= DUTY_MAX))
        else $error("held duty out of range");

    a_nontick_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && r_cmd != CMD_TICK && (!r_out_valid || i_ready))
        |=> (o_valid && !o_on_line && o_line_position == '0))
        else $error("non-tick item reported a position");

endmodule
